@@ rtl/exclusive_time_profiler_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the exclusive time profiler
// ---------------------------------------------------------------------------
`ifndef EXCLUSIVE_TIME_PROFILER_TOP_MACROS_SVH
`define EXCLUSIVE_TIME_PROFILER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define ETP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ETP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/etp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Exclusive time profiler package
// Field widths, command and error codes, totals table request word.
// ---------------------------------------------------------------------------
package etp_pkg;

  localparam int FUNC_ID_W = 8;
  localparam int TS_W      = 32;
  localparam int CFG_W     = 9;
  localparam int ERR_W     = 2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_END   = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL      = 2'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_ID    = 2'd3;

  localparam logic [CFG_W-1:0] NUM_FUNC_RESET = 9'd256;

  // request word to the totals table
  typedef struct packed {
    logic                 rd;   // read the entry of id
    logic                 add;  // write back read total plus duration
    logic [FUNC_ID_W-1:0] id;
  } tot_req_t;

endpackage

@@ rtl/exclusive_time_profiler_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Exclusive time profiler
// Call-stack profiler: start events push a start time, end events charge
// the inclusive duration to the function and shift all enclosing starts.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  event     start / busy           command, func_id, timestamp
//  config    cfg_we                 cfg_data (num_functions)
//  result    done (one-cycle pulse) out_func_id, added_time, total_time,
//                                   error_code
//
//  A start event or a rejected event leaves busy low. An end event holds
//  busy through one read of the top and the total, one duration step, one
//  total write, then a read-modify-write walk of the stack memory port.
//  After reset busy is high while the totals memory is cleared. Results
//  cannot be stalled.
// ---------------------------------------------------------------------------
module exclusive_time_profiler_top #(
  parameter int STACK_DEPTH   = 64,
  parameter int MAX_FUNCTIONS = 256,
  parameter int TIME_WIDTH    = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command,
  input  logic [etp_pkg::FUNC_ID_W-1:0]  func_id,
  input  logic [etp_pkg::TS_W-1:0]       timestamp,
  input  logic                           cfg_we,
  input  logic [etp_pkg::CFG_W-1:0]      cfg_data,
  output logic                           done,
  output logic [etp_pkg::FUNC_ID_W-1:0]  out_func_id,
  output logic [etp_pkg::TS_W-1:0]       added_time,
  output logic [etp_pkg::TS_W-1:0]       total_time,
  output logic [etp_pkg::ERR_W-1:0]      error_code
);
  import etp_pkg::*;

  `include "exclusive_time_profiler_top_macros.svh"

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;

  logic [2:0]            state;
  logic [CFG_W-1:0]      num_functions;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_dec;
  logic [CNT_W-1:0]      walk_idx;
  logic                  pend;
  logic [ADDR_W-1:0]     wr_addr;
  logic [FUNC_ID_W-1:0]  id_q;
  logic [TIME_WIDTH:0]   ts_inc;
  logic [TIME_WIDTH-1:0] dur;
  logic [TIME_WIDTH-1:0] dur_next;
  logic [TIME_WIDTH:0]   diff;
  logic [TIME_WIDTH-1:0] ts_t;

  logic [TIME_WIDTH-1:0] stk_mem [STACK_DEPTH];
  logic [TIME_WIDTH-1:0] stk_rd;
  logic [TIME_WIDTH-1:0] shifted;
  logic [TIME_WIDTH:0]   shift_sum;
  logic [ADDR_W-1:0]     stk_ra;
  logic [ADDR_W-1:0]     stk_wa;
  logic [TIME_WIDTH-1:0] stk_wd;
  logic                  stk_re;
  logic                  stk_we;

  logic                  accept;
  logic                  id_ok;
  logic                  full;
  logic                  empty;
  logic                  push;
  logic                  pop_start;
  logic                  walk_issue;

  tot_req_t              tot_req;
  logic [TIME_WIDTH-1:0] new_total;
  logic                  tot_clearing;

  etp_totals #(
    .MAX_FUNCTIONS(MAX_FUNCTIONS),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_totals (
    .clk      (clk),
    .rst      (rst),
    .req      (tot_req),
    .dur      (dur),
    .new_total(new_total),
    .clearing (tot_clearing)
  );

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign ts_t      = TIME_WIDTH'(timestamp);
  assign id_ok     = ({1'b0, func_id} < num_functions) &&
                     (32'(func_id) < 32'(MAX_FUNCTIONS));
  assign full      = (count == CNT_W'(STACK_DEPTH));
  assign empty     = (count == '0);
  assign push      = accept && id_ok && (command == CMD_START) && !full;
  assign pop_start = accept && id_ok && (command == CMD_END) && !empty;
  assign count_dec = count - 1'b1;
  assign walk_issue = (state == ST_WALK) && (walk_idx < count);

  // inclusive duration: ts + 1 - top, zero when the end precedes the start
  assign diff = ts_inc - {1'b0, stk_rd};
  always_comb begin
    if (ts_inc > {1'b0, stk_rd}) begin
      dur_next = diff[TIME_WIDTH] ? '1 : diff[TIME_WIDTH-1:0];
    end else begin
      dur_next = '0;
    end
  end

  assign shift_sum = {1'b0, stk_rd} + {1'b0, dur};
  assign shifted   = shift_sum[TIME_WIDTH] ? '1 : shift_sum[TIME_WIDTH-1:0];

  assign stk_re = pop_start || walk_issue;
  assign stk_ra = (state == ST_WALK) ? walk_idx[ADDR_W-1:0] : count_dec[ADDR_W-1:0];
  assign stk_we = push || ((state == ST_WALK) && pend);
  assign stk_wa = push ? count[ADDR_W-1:0] : wr_addr;
  assign stk_wd = push ? ts_t : shifted;

  always_comb begin
    tot_req.rd  = pop_start;
    tot_req.add = (state == ST_SUM);
    tot_req.id  = pop_start ? func_id : id_q;
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd <= stk_mem[stk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      num_functions <= NUM_FUNC_RESET;
      count         <= '0;
      walk_idx      <= '0;
      pend          <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        num_functions <= cfg_data;
      end
      unique case (state)
        ST_CLEAR: begin
          if (!tot_clearing) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            out_func_id <= func_id;
            added_time  <= '0;
            total_time  <= '0;
            id_q        <= func_id;
            ts_inc      <= {1'b0, ts_t} + 1'b1;
            if (!id_ok) begin
              done       <= 1'b1;
              error_code <= ERR_BAD_ID;
            end else if (command == CMD_START) begin
              if (full) begin
                done       <= 1'b1;
                error_code <= ERR_FULL;
              end else begin
                count <= count + 1'b1;
              end
            end else if (empty) begin
              done       <= 1'b1;
              error_code <= ERR_EMPTY;
            end else begin
              state <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          dur      <= dur_next;
          count    <= count_dec;
          walk_idx <= '0;
          pend     <= 1'b0;
          state    <= ST_SUM;
        end
        ST_SUM: begin
          done        <= 1'b1;
          out_func_id <= id_q;
          added_time  <= TS_W'(dur);
          total_time  <= TS_W'(new_total);
          error_code  <= ERR_OK;
          state       <= ST_WALK;
        end
        ST_WALK: begin
          // read entry k while writing back entry k-1
          if (walk_issue) begin
            walk_idx <= walk_idx + 1'b1;
            wr_addr  <= walk_idx[ADDR_W-1:0];
            pend     <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ETP_ASSERT_NOW(a_no_result_while_clearing, tot_clearing, !done,
                  "result during totals clearing")
  `ETP_ASSERT_NEXT(a_push_counts, push, count == $past(count) + 1'b1,
                   "push did not advance stack count")
  `ETP_ASSERT_NOW(a_walk_in_range, (state == ST_WALK) && pend,
                  CNT_W'(wr_addr) < count, "walk write beyond stack top")
  `ETP_ASSERT_NOW(a_error_zero_payload, done && (error_code != ERR_OK),
                  (added_time == '0) && (total_time == '0),
                  "error result with nonzero times")
  `ETP_ASSERT_NEXT(a_end_goes_busy, pop_start, busy && (state == ST_CALC),
                   "end event did not start duration step")

endmodule

@@ rtl/etp_totals.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Totals table
// Per-function saturating totals in a registered-read memory, cleared by
// a sweep after reset.
// ---------------------------------------------------------------------------
module etp_totals #(
  parameter int MAX_FUNCTIONS = 256,
  parameter int TIME_WIDTH    = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  etp_pkg::tot_req_t     req,
  input  logic [TIME_WIDTH-1:0] dur,
  output logic [TIME_WIDTH-1:0] new_total,
  output logic                  clearing
);
  import etp_pkg::*;

  localparam int IDX_W = $clog2(MAX_FUNCTIONS);

  logic [TIME_WIDTH-1:0] mem [MAX_FUNCTIONS];
  logic [TIME_WIDTH-1:0] rd_data;
  logic [IDX_W-1:0]      clr_idx;
  logic [IDX_W-1:0]      idx;
  logic [TIME_WIDTH:0]   sum;

  assign idx       = IDX_W'(req.id);
  assign sum       = {1'b0, rd_data} + {1'b0, dur};
  assign new_total = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == IDX_W'(MAX_FUNCTIONS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (req.add) begin
      mem[idx] <= new_total;
    end
    if (req.rd) begin
      rd_data <= mem[idx];
    end
  end

endmodule
